FILE: rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the stereo frame ring buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int unsigned RING_FRAMES_DEF = 4096;
  localparam int unsigned FRAME_W         = 64;
  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned WORD_W          = 2 * SAMPLE_W;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WORD_W-1:0]   word_t;

endpackage

FILE: rtl/srb_if.sv
// ----------------------------------------------------------------------------
// srb_if
// Valid/ready channels of the stereo frame ring buffer.
// ----------------------------------------------------------------------------
interface srb_in_if;
  logic              valid;
  logic              ready;
  srb_pkg::op_t      op;
  srb_pkg::frame_t   frame_number;
  srb_pkg::sample_t  left_sample;
  srb_pkg::sample_t  right_sample;
  logic              batch_end;

  modport source (
    output valid, op, frame_number, left_sample, right_sample, batch_end,
    input  ready
  );
  modport sink (
    input  valid, op, frame_number, left_sample, right_sample, batch_end,
    output ready
  );
endinterface

interface srb_out_if;
  logic              valid;
  logic              ready;
  srb_pkg::sample_t  left_out;
  srb_pkg::sample_t  right_out;
  logic              present;

  modport source (
    output valid, left_out, right_out, present,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out, present,
    output ready
  );
endinterface

FILE: rtl/stereo_frame_ring_buffer.sv
// ----------------------------------------------------------------------------
// stereo_frame_ring_buffer
// Ring of stereo frames addressed by absolute frame number, with a watermark
// that closes each write run.
//
//   channel | dir | transfer carries
//   --------+-----+---------------------------------------------------------
//   in_ch   | in  | op, frame_number, left_sample, right_sample, batch_end
//   out_ch  | out | left_out, right_out, present (one per read, none per write)
//
// One item per cycle while in_ch.ready is high; a read result passes the
// frame RAM's registered read, then the output register, before it is
// valid on out_ch.
// After reset a clearing pass zeroes every RAM slot, one slot a cycle;
// in_ch.ready stays low until it ends.
// A stalled output holds one result in the read stage; in_ch stalls only
// during the clearing pass or when that stage and the output register are
// both full and out_ch.ready is low.
// ----------------------------------------------------------------------------
module stereo_frame_ring_buffer #(
  parameter int unsigned RING_FRAMES = srb_pkg::RING_FRAMES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  srb_in_if.sink     in_ch,
  srb_out_if.source  out_ch
);

  localparam int unsigned AW = $clog2(RING_FRAMES);
  localparam int unsigned FW = srb_pkg::FRAME_W;
  localparam int unsigned SW = srb_pkg::SAMPLE_W;

  // control state
  logic                clearing_r, clearing_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  srb_pkg::frame_t     wm_r, wm_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_hit_r, s1_hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  srb_pkg::sample_t    out_left_r, out_left_nxt;
  srb_pkg::sample_t    out_right_r, out_right_nxt;
  logic                out_present_r, out_present_nxt;

  logic                in_xfer, wr_xfer, rd_xfer, s1_adv;
  logic [FW:0]         diff;
  logic                hit;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  srb_pkg::word_t      ram_wdata;
  srb_pkg::word_t      ram_rdata;

  assign s1_adv       = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready  = ~clearing_r & (~s1_valid_r | s1_adv);
  assign in_xfer      = in_ch.valid & in_ch.ready;
  assign wr_xfer      = in_xfer & (in_ch.op == srb_pkg::OP_WRITE);
  assign rd_xfer      = in_xfer & (in_ch.op == srb_pkg::OP_READ);

  // window check: frame < wm and wm - frame <= RING_FRAMES
  assign diff = {1'b0, wm_r} - {1'b0, in_ch.frame_number};
  assign hit  = ~diff[FW] && (diff[FW-1:0] != '0) && (diff[FW-1:AW+1] == '0)
                && (diff[AW:0] <= (AW+1)'(RING_FRAMES));

  always_comb begin
    ram_we    = clearing_r | wr_xfer;
    ram_waddr = clearing_r ? clr_addr_r : in_ch.frame_number[AW-1:0];
    ram_wdata = clearing_r ? '0 : {in_ch.right_sample, in_ch.left_sample};
  end

  srb_ram #(
    .WIDTH (srb_pkg::WORD_W),
    .DEPTH (RING_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_xfer),
    .raddr (in_ch.frame_number[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    clearing_nxt    = clearing_r;
    clr_addr_nxt    = clr_addr_r;
    wm_nxt          = wm_r;
    s1_valid_nxt    = rd_xfer | (s1_valid_r & ~s1_adv);
    s1_hit_nxt      = rd_xfer ? hit : s1_hit_r;
    out_valid_nxt   = out_valid_r;
    out_left_nxt    = out_left_r;
    out_right_nxt   = out_right_r;
    out_present_nxt = out_present_r;

    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == {AW{1'b1}}) begin
        clearing_nxt = 1'b0;
      end
    end

    if (wr_xfer && in_ch.batch_end) begin
      wm_nxt = in_ch.frame_number + FW'(1);
    end

    if (s1_adv) begin
      out_valid_nxt   = 1'b1;
      out_left_nxt    = s1_hit_r ? ram_rdata[SW-1:0] : '0;
      out_right_nxt   = s1_hit_r ? ram_rdata[2*SW-1:SW] : '0;
      out_present_nxt = s1_hit_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      wm_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wm_r        <= wm_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit_r      <= s1_hit_nxt;
    out_left_r    <= out_left_nxt;
    out_right_r   <= out_right_nxt;
    out_present_r <= out_present_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_left_r;
  assign out_ch.right_out = out_right_r;
  assign out_ch.present   = out_present_r;

`ifndef NO_ASSERTIONS
  a_no_xfer_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ch.ready)
    else $error("transfer possible during clearing pass");

  a_read_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |=> s1_valid_r)
    else $error("read stage dropped a pending result");

  a_absent_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_present_r) |-> (out_left_r == '0 && out_right_r == '0))
    else $error("absent frame carries nonzero samples");

  a_watermark_update: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_xfer && in_ch.batch_end) |=> (wm_r == $past(in_ch.frame_number) + FW'(1)))
    else $error("watermark not moved by closing write");
`endif

endmodule

FILE: rtl/srb_ram.sv
// ----------------------------------------------------------------------------
// srb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srb_ram #(
  parameter int unsigned WIDTH = srb_pkg::WORD_W,
  parameter int unsigned DEPTH = srb_pkg::RING_FRAMES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
